// ===== rtl/gda_pkg.sv =====
// ----------------------------------------------------------------------------
// gda_pkg
// Shared constants and calendar helpers for the Gregorian date arithmetic core.
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int YR_W    = 17;   // internal year width, covers years up to 131071
    localparam int SER_W   = 25;   // day serial width, covers 65535 years
    localparam int DIST_W  = 22;
    localparam int DOY_W   = 9;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_SUB  = 2'd1;
    localparam logic [1:0] REQ_DIFF = 2'd2;

    // floor(x / 100) = (x * K100) >> K100_SH for x < 2^YR_W
    localparam int          K100_SH = 26;
    localparam logic [19:0] K100    = 20'd671089;
    // year estimate, rounded up: ((n + 3) * KYR) >> KYR_SH
    localparam int          KYR_SH  = 28;
    localparam logic [19:0] KYR     = 20'd734952;

    localparam logic [6:0] R99 = 7'd99;

    // days before the first of month m in a common year
    function automatic logic [DOY_W-1:0] cum_days(input logic [3:0] m);
        logic [DOY_W-1:0] c;
        unique case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] l;
        unique case (m)
            4'd2:                       l = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    l = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:         l = 5'd31;
            default:                    l = 5'd0;
        endcase
        return l;
    endfunction

    // leap test of year x, given q = x / 100 and r = x % 100
    function automatic logic leap_of(input logic [1:0] x_lo, input logic [1:0] q_lo,
                                     input logic [6:0] r);
        return ((x_lo == 2'd0) && (r != 7'd0)) || ((r == 7'd0) && (q_lo == 2'd0));
    endfunction

    // leap test of year x + 1, given q = x / 100 and r = x % 100
    function automatic logic leap_next(input logic [1:0] x_lo, input logic [1:0] q_lo,
                                       input logic [6:0] r);
        return ((x_lo == 2'd3) && (r != R99)) || ((r == R99) && (q_lo == 2'd3));
    endfunction

endpackage

// ===== rtl/gregorian_date_arithmetic_core.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_core
// Gregorian date add/subtract of a day offset, and day count between two dates.
//
// Usage:
//   A request is taken at a rising edge with start high; busy is always low,
//   so a new request may be issued every cycle.
//   i_req_type selects add, subtract or day difference. The first date and the
//   offset feed add/subtract; the difference also uses the second date.
//   Each result appears on the o_ ports for one cycle with o_result_valid high,
//   in request order. One result per request, one request per cycle sustained.
//   The pipeline is the input register, three stages of date to serial, two
//   stages of offset add and range check, five stages of serial to date, and
//   the output register.
//   Invalid dates, out-of-range results and unused request codes set
//   o_range_error and return the first date unchanged.
//   Reset clears all in-flight requests. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_core
    import gda_pkg::*;
#(
    parameter int MAX_YEAR    = 9999,
    parameter int OFFSET_BITS = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_req_type,
    input  logic [13:0]                   i_first_year,
    input  logic [3:0]                    i_first_month,
    input  logic [4:0]                    i_first_day,
    input  logic signed [OFFSET_BITS-1:0] i_day_offset,
    input  logic [13:0]                   i_second_year,
    input  logic [3:0]                    i_second_month,
    input  logic [4:0]                    i_second_day,
    output logic                          o_result_valid,
    output logic [13:0]                   o_result_year,
    output logic [3:0]                    o_result_month,
    output logic [4:0]                    o_result_day,
    output logic [DIST_W-1:0]             o_day_distance,
    output logic                          o_first_is_later,
    output logic                          o_range_error
);

    localparam int TGT_W   = ((SER_W > OFFSET_BITS) ? SER_W : OFFSET_BITS) + 2;
    localparam int MAX_SER = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                             + MAX_YEAR / 400 - 1;
    localparam int SER_LAT = 3;
    localparam int CIV_LAT = 5;
    localparam int LAT     = SER_LAT + CIV_LAT + 4;

    typedef struct packed {
        logic [1:0]             req;
        logic [13:0]            year;
        logic [3:0]             month;
        logic [4:0]             day;
        logic [OFFSET_BITS-1:0] off;
    } t_ctl;

    typedef struct packed {
        logic              use_civil;
        logic              err;
        logic [13:0]       year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [DIST_W-1:0] distance;
        logic              later;
    } t_res;

    assign busy = 1'b0;

    // input register
    logic r0_v, r0_second_unused;
    t_ctl r0_ctl;
    logic [13:0] r0_y2;
    logic [3:0]  r0_m2;
    logic [4:0]  r0_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= start;
        end
        r0_ctl <= '{req: i_req_type, year: i_first_year, month: i_first_month,
                    day: i_first_day, off: i_day_offset};
        r0_y2  <= i_second_year;
        r0_m2  <= i_second_month;
        r0_d2  <= i_second_day;
        r0_second_unused <= 1'b0;
    end

    // date to serial
    logic             s1_v, s2_v, s1_ok, s2_ok;
    logic [SER_W-1:0] s1_ser, s2_ser;

    gda_serial #(.MAX_YEAR(MAX_YEAR)) u_ser_first (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r0_v),
        .i_year    (r0_ctl.year),
        .i_month   (r0_ctl.month),
        .i_day     (r0_ctl.day),
        .o_valid   (s1_v),
        .o_serial  (s1_ser),
        .o_date_ok (s1_ok)
    );

    gda_serial #(.MAX_YEAR(MAX_YEAR)) u_ser_second (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r0_v && !r0_second_unused),
        .i_year    (r0_y2),
        .i_month   (r0_m2),
        .i_day     (r0_d2),
        .o_valid   (s2_v),
        .o_serial  (s2_ser),
        .o_date_ok (s2_ok)
    );

    t_ctl r_ctl_dly [SER_LAT];

    always_ff @(posedge i_clk) begin
        r_ctl_dly[0] <= r0_ctl;
        for (int i = 1; i < SER_LAT; i++) begin
            r_ctl_dly[i] <= r_ctl_dly[i-1];
        end
    end

    // offset add, difference
    logic                    r4_v, r4_ok1, r4_ok2, r4_later;
    logic signed [TGT_W-1:0] r4_n;
    logic [DIST_W-1:0]       r4_dist;
    t_ctl                    r4_ctl;
    t_ctl                    n4_ctl;
    logic signed [TGT_W-1:0] n4_off, n4_ser;
    logic [SER_W-1:0]        n4_diff;

    assign n4_ctl  = r_ctl_dly[SER_LAT-1];
    assign n4_off  = TGT_W'($signed(n4_ctl.off));
    assign n4_ser  = $signed({{(TGT_W-SER_W){1'b0}}, s1_ser});
    assign n4_diff = (s1_ser > s2_ser) ? (s1_ser - s2_ser) : (s2_ser - s1_ser);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= s1_v && s2_v;
        end
        r4_ctl   <= n4_ctl;
        r4_ok1   <= s1_ok;
        r4_ok2   <= s2_ok;
        r4_n     <= (n4_ctl.req == REQ_SUB) ? (n4_ser - n4_off) : (n4_ser + n4_off);
        r4_later <= s1_ser > s2_ser;
        r4_dist  <= (n4_diff > SER_W'(DIST_MAX)) ? DIST_MAX : n4_diff[DIST_W-1:0];
    end

    // range check, error resolve
    logic             r5_v;
    logic [SER_W-1:0] r5_n;
    t_res             r5_res;
    logic             n5_oor, n5_err;

    assign n5_oor = (r4_n < 0) || (r4_n > $signed(TGT_W'(MAX_SER)));

    always_comb begin
        unique case (r4_ctl.req)
            REQ_ADD, REQ_SUB: n5_err = !r4_ok1 || n5_oor;
            REQ_DIFF:         n5_err = !r4_ok1 || !r4_ok2;
            default:          n5_err = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_n   <= r4_n[SER_W-1:0];
        r5_res <= '{use_civil: !n5_err && ((r4_ctl.req == REQ_ADD) ||
                                           (r4_ctl.req == REQ_SUB)),
                    err:      n5_err,
                    year:     r4_ctl.year,
                    month:    r4_ctl.month,
                    day:      r4_ctl.day,
                    distance: (!n5_err && (r4_ctl.req == REQ_DIFF)) ? r4_dist : '0,
                    later:    !n5_err && (r4_ctl.req == REQ_DIFF) && r4_later};
    end

    // serial to date
    logic            c_v;
    logic [YR_W-1:0] c_year;
    logic [3:0]      c_month;
    logic [4:0]      c_day;

    gda_civil u_civil (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r5_v),
        .i_serial (r5_n),
        .o_valid  (c_v),
        .o_year   (c_year),
        .o_month  (c_month),
        .o_day    (c_day)
    );

    t_res r_res_dly [CIV_LAT];

    always_ff @(posedge i_clk) begin
        r_res_dly[0] <= r5_res;
        for (int i = 1; i < CIV_LAT; i++) begin
            r_res_dly[i] <= r_res_dly[i-1];
        end
    end

    // output register
    t_res n_out;
    logic r_out_v;
    t_res r_out;

    assign n_out = r_res_dly[CIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= c_v;
        end
        r_out <= n_out;
        if (n_out.use_civil) begin
            r_out.year  <= c_year[13:0];
            r_out.month <= c_month;
            r_out.day   <= c_day;
        end
    end

    assign o_result_valid   = r_out_v;
    assign o_result_year    = r_out.year;
    assign o_result_month   = r_out.month;
    assign o_result_day     = r_out.day;
    assign o_day_distance   = r_out.distance;
    assign o_first_is_later = r_out.later;
    assign o_range_error    = r_out.err;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_result_valid)
        else $error("request lost in pipeline");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_range_error |-> (o_day_distance == '0) && !o_first_is_later)
        else $error("distance reported with error");

    a_later_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_first_is_later |-> o_day_distance != '0)
        else $error("later flag with zero distance");

    a_date_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_range_error |->
            (o_result_month >= 4'd1) && (o_result_month <= 4'd12) && (o_result_day != 5'd0))
        else $error("bad result date");

endmodule

// ===== rtl/gda_serial.sv =====
// ----------------------------------------------------------------------------
// gda_serial
// Three-stage pipeline: date to day serial (0001-01-01 is day 0) plus validity.
// ----------------------------------------------------------------------------
module gda_serial
    import gda_pkg::*;
#(
    parameter int MAX_YEAR = 9999
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [13:0]      i_year,
    input  logic [3:0]       i_month,
    input  logic [4:0]       i_day,
    output logic             o_valid,
    output logic [SER_W-1:0] o_serial,
    output logic             o_date_ok
);

    localparam logic [YR_W-1:0] MAXY = YR_W'(MAX_YEAR);

    // stage 1
    logic             r1_v, r1_yok;
    logic [YR_W-1:0]  r1_p, r1_q;
    logic [SER_W-1:0] r1_p365;
    logic [3:0]       r1_m;
    logic [4:0]       r1_d;
    logic [YR_W-1:0]  n1_p;
    logic [YR_W+19:0] n1_qprod;

    assign n1_p     = {{(YR_W-14){1'b0}}, i_year} - YR_W'(1);
    assign n1_qprod = n1_p * K100;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
        r1_p    <= n1_p;
        r1_q    <= n1_qprod[K100_SH +: YR_W];
        r1_p365 <= SER_W'(n1_p * 9'd365);
        r1_yok  <= (i_year != 14'd0) && ({{(YR_W-14){1'b0}}, i_year} <= MAXY);
        r1_m    <= i_month;
        r1_d    <= i_day;
    end

    // stage 2
    logic             r2_v, r2_ok, r2_leap;
    logic [SER_W-1:0] r2_base;
    logic [3:0]       r2_m;
    logic [4:0]       r2_d;
    logic [YR_W-1:0]  n2_r;
    logic             n2_leap, n2_ok;

    assign n2_r    = r1_p - YR_W'(r1_q * YR_W'(100));
    assign n2_leap = leap_next(r1_p[1:0], r1_q[1:0], n2_r[6:0]);
    assign n2_ok   = r1_yok && (r1_m >= 4'd1) && (r1_m <= 4'd12) && (r1_d != 5'd0)
                     && (r1_d <= month_len(r1_m, n2_leap));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_base <= r1_p365 + SER_W'(r1_p >> 2) - SER_W'(r1_q) + SER_W'(r1_q >> 2);
        r2_leap <= n2_leap;
        r2_ok   <= n2_ok;
        r2_m    <= r1_m;
        r2_d    <= r1_d;
    end

    // stage 3
    logic             r3_v, r3_ok;
    logic [SER_W-1:0] r3_ser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_ser <= r2_base + SER_W'(cum_days(r2_m))
                  + SER_W'(r2_leap && (r2_m > 4'd2)) + SER_W'(r2_d) - SER_W'(1);
        r3_ok  <= r2_ok;
    end

    assign o_valid   = r3_v;
    assign o_serial  = r3_ser;
    assign o_date_ok = r3_ok;

endmodule

// ===== rtl/gda_civil.sv =====
// ----------------------------------------------------------------------------
// gda_civil
// Five-stage pipeline: day serial back to year, month and day.
// ----------------------------------------------------------------------------
module gda_civil
    import gda_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [SER_W-1:0] i_serial,
    output logic             o_valid,
    output logic [YR_W-1:0]  o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day
);

    // stage 1: year estimate, equal to or one above the elapsed years
    logic               r1_v;
    logic [SER_W-1:0]   r1_n;
    logic [YR_W-1:0]    r1_pe;
    logic [SER_W+20:0]  n1_prod;

    assign n1_prod = ({1'b0, i_serial} + (SER_W+1)'(3)) * KYR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
        r1_n  <= i_serial;
        r1_pe <= n1_prod[KYR_SH +: YR_W];
    end

    // stage 2
    logic             r2_v;
    logic [SER_W-1:0] r2_n, r2_p365;
    logic [YR_W-1:0]  r2_pe, r2_q;
    logic [YR_W+19:0] n2_qprod;

    assign n2_qprod = r1_pe * K100;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_n    <= r1_n;
        r2_pe   <= r1_pe;
        r2_q    <= n2_qprod[K100_SH +: YR_W];
        r2_p365 <= SER_W'(r1_pe * 9'd365);
    end

    // stage 3: first day of year pe + 1
    logic             r3_v, r3_leap_pe, r3_leap_nx;
    logic [SER_W-1:0] r3_n, r3_start;
    logic [YR_W-1:0]  r3_pe;
    logic [YR_W-1:0]  n3_r;

    assign n3_r = r2_pe - YR_W'(r2_q * YR_W'(100));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_n       <= r2_n;
        r3_pe      <= r2_pe;
        r3_start   <= r2_p365 + SER_W'(r2_pe >> 2) - SER_W'(r2_q) + SER_W'(r2_q >> 2);
        r3_leap_pe <= leap_of(r2_pe[1:0], r2_q[1:0], n3_r[6:0]);
        r3_leap_nx <= leap_next(r2_pe[1:0], r2_q[1:0], n3_r[6:0]);
    end

    // stage 4: pick year, day of year
    logic             r4_v, r4_leap;
    logic [YR_W-1:0]  r4_year;
    logic [DOY_W-1:0] r4_doy;
    logic [SER_W-1:0] n4_rem;

    assign n4_rem = r3_n - r3_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        if (r3_n < r3_start) begin
            r4_year <= r3_pe;
            r4_doy  <= DOY_W'(n4_rem + SER_W'(365) + SER_W'(r3_leap_pe));
            r4_leap <= r3_leap_pe;
        end else begin
            r4_year <= r3_pe + YR_W'(1);
            r4_doy  <= n4_rem[DOY_W-1:0];
            r4_leap <= r3_leap_nx;
        end
    end

    // stage 5: month and day
    logic             r5_v;
    logic [YR_W-1:0]  r5_year;
    logic [3:0]       r5_m;
    logic [4:0]       r5_d;
    logic [3:0]       n5_m;
    logic [DOY_W-1:0] n5_first;

    always_comb begin
        n5_m     = 4'd1;
        n5_first = '0;
        for (int k = 2; k <= 12; k++) begin
            if (r4_doy >= cum_days(4'(k)) + DOY_W'(r4_leap && (k > 2))) begin
                n5_m     = 4'(k);
                n5_first = cum_days(4'(k)) + DOY_W'(r4_leap && (k > 2));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_year <= r4_year;
        r5_m    <= n5_m;
        r5_d    <= 5'(r4_doy - n5_first + DOY_W'(1));
    end

    assign o_valid = r5_v;
    assign o_year  = r5_year;
    assign o_month = r5_m;
    assign o_day   = r5_d;

endmodule

// ===== test/gregorian_date_arithmetic_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_checker
// Watches accepted requests and strobed results of the date core, computes the
// expected date, distance and flags per request, and compares them in order.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_checker
    import gda_pkg::*;
#(
    parameter int MAX_YEAR    = 9999,
    parameter int OFFSET_BITS = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [1:0]                    i_req_type,
    input  logic [13:0]                   i_first_year,
    input  logic [3:0]                    i_first_month,
    input  logic [4:0]                    i_first_day,
    input  logic signed [OFFSET_BITS-1:0] i_day_offset,
    input  logic [13:0]                   i_second_year,
    input  logic [3:0]                    i_second_month,
    input  logic [4:0]                    i_second_day,
    input  logic                          o_result_valid,
    input  logic [13:0]                   o_result_year,
    input  logic [3:0]                    o_result_month,
    input  logic [4:0]                    o_result_day,
    input  logic [DIST_W-1:0]             o_day_distance,
    input  logic                          o_first_is_later,
    input  logic                          o_range_error,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic [13:0]       year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [DIST_W-1:0] distance;
        logic              later;
        logic              err;
    } t_date_result;

    t_date_result expected_dates[$];

    function automatic bit leap_year(longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint month_days(longint y, longint m);
        case (m)
            2: return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            1, 3, 5, 7, 8, 10, 12: return 31;
            default: return 0;
        endcase
    endfunction

    function automatic bit valid_date(longint y, longint m, longint d);
        if (y < 1 || y > MAX_YEAR || m < 1 || m > 12) return 0;
        return d >= 1 && d <= month_days(y, m);
    endfunction

    function automatic longint day_serial(longint y, longint m, longint d);
        longint p;
        longint n;
        p = y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (longint k = 1; k < m; k++) n += month_days(y, k);
        return n + d - 1;
    endfunction

    function automatic t_date_result predict_date(logic [1:0] rq, longint y1, longint m1,
                                                  longint d1, longint off, longint y2,
                                                  longint m2, longint d2);
        t_date_result r;
        longint n;
        longint a;
        longint b;
        longint y;
        longint m;
        r = '0;
        r.year = 14'(y1); r.month = 4'(m1); r.day = 5'(d1);
        if (rq == REQ_ADD || rq == REQ_SUB) begin
            if (!valid_date(y1, m1, d1)) begin
                r.err = 1'b1;
            end else begin
                n = day_serial(y1, m1, d1) + (rq == REQ_ADD ? off : -off);
                if (n < 0 || n > day_serial(MAX_YEAR, 12, 31)) begin
                    r.err = 1'b1;
                end else begin
                    y = n / 146097 * 400 + 1;
                    while (day_serial(y + 1, 1, 1) <= n) y++;
                    n -= day_serial(y, 1, 1);
                    m = 1;
                    while (m < 12 && n >= month_days(y, m)) begin
                        n -= month_days(y, m);
                        m++;
                    end
                    r.year = 14'(y); r.month = 4'(m); r.day = 5'(n + 1);
                end
            end
        end else if (rq == REQ_DIFF) begin
            if (!valid_date(y1, m1, d1) || !valid_date(y2, m2, d2)) begin
                r.err = 1'b1;
            end else begin
                a = day_serial(y1, m1, d1);
                b = day_serial(y2, m2, d2);
                r.later = a > b;
                n = a > b ? a - b : b - a;
                r.distance = n > 4194303 ? DIST_MAX : DIST_W'(n);
            end
        end else begin
            r.err = 1'b1;
        end
        return r;
    endfunction

    assign o_pending = expected_dates.size();

    always @(posedge i_clk) begin
        t_date_result exp_r;
        t_date_result act_r;
        if (!i_rst_n) begin
            expected_dates.delete();
            o_fail_count <= 0;
        end else begin
            if (o_result_valid) begin
                act_r = '{o_result_year, o_result_month, o_result_day, o_day_distance,
                          o_first_is_later, o_range_error};
                if (expected_dates.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result %p", act_r);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_dates.pop_front();
                    if (exp_r !== act_r) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p actual %p", exp_r, act_r);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_dates.push_back(predict_date(i_req_type, i_first_year,
                    i_first_month, i_first_day, longint'(i_day_offset), i_second_year,
                    i_second_month, i_second_day));
        end
    end

endmodule

// ===== test/gregorian_date_arithmetic_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_core_tb
// Drives directed and random date requests into the core under several idle
// patterns; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_core_tb;
    import gda_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              start = 0;
    logic              busy;
    logic [1:0]        i_req_type = REQ_ADD;
    logic [13:0]       i_first_year = 1;
    logic [3:0]        i_first_month = 1;
    logic [4:0]        i_first_day = 1;
    logic signed [16:0] i_day_offset = 0;
    logic [13:0]       i_second_year = 1;
    logic [3:0]        i_second_month = 1;
    logic [4:0]        i_second_day = 1;
    logic              o_result_valid;
    logic [13:0]       o_result_year;
    logic [3:0]        o_result_month;
    logic [4:0]        o_result_day;
    logic [DIST_W-1:0] o_day_distance;
    logic              o_first_is_later;
    logic              o_range_error;
    int                fail_count;
    int                pending;
    int                idle_pct;
    int                quiet_cycles = 0;

    localparam int WATCHDOG = 20000;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    gregorian_date_arithmetic_core dut (.*);
    gregorian_date_arithmetic_checker checker_i (.*, .o_fail_count(fail_count),
                                                  .o_pending(pending));

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] rq, int y1, int m1, int d1, int off,
                                int y2, int m2, int d2);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start          <= 1;
        i_req_type     <= rq;
        i_first_year   <= 14'(y1);
        i_first_month  <= 4'(m1);
        i_first_day    <= 5'(d1);
        i_day_offset   <= 17'(off);
        i_second_year  <= 14'(y2);
        i_second_month <= 4'(m2);
        i_second_day   <= 5'(d2);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_random();
        int dice;
        dice = $urandom_range(99);
        if (dice < 80)
            send_request(2'($urandom_range(2)), $urandom_range(9999, 1),
                         $urandom_range(12, 1), $urandom_range(28, 1),
                         $urandom_range(3) == 0 ? $signed($urandom()) % 65536
                                                : $signed($urandom()) % 1000,
                         $urandom_range(9999, 1), $urandom_range(12, 1),
                         $urandom_range(31, 1));
        else
            send_request(2'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom());
    endtask

    initial begin
        idle_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_request(REQ_ADD, 1, 1, 1, 0, 1, 1, 1);
        send_request(REQ_SUB, 1, 1, 1, 1, 1, 1, 1);
        send_request(REQ_ADD, 9999, 12, 31, 1, 1, 1, 1);
        send_request(REQ_ADD, 9999, 12, 31, -65535, 1, 1, 1);
        send_request(REQ_ADD, 1, 1, 1, 65535, 1, 1, 1);
        send_request(REQ_SUB, 5000, 6, 15, -65536, 1, 1, 1);
        send_request(REQ_ADD, 2000, 2, 28, 1, 1, 1, 1);
        send_request(REQ_ADD, 1900, 2, 28, 1, 1, 1, 1);
        send_request(REQ_SUB, 2024, 3, 1, 1, 1, 1, 1);
        send_request(REQ_ADD, 2023, 2, 29, 0, 1, 1, 1);
        send_request(REQ_ADD, 2024, 2, 30, 0, 1, 1, 1);
        send_request(REQ_ADD, 0, 1, 1, 0, 1, 1, 1);
        send_request(REQ_ADD, 16383, 15, 31, 0, 1, 1, 1);
        send_request(REQ_SUB, 2000, 0, 0, 5, 1, 1, 1);
        send_request(REQ_DIFF, 1, 1, 1, 0, 9999, 12, 31);
        send_request(REQ_DIFF, 9999, 12, 31, 0, 1, 1, 1);
        send_request(REQ_DIFF, 2020, 5, 5, 0, 2020, 5, 5);
        send_request(REQ_DIFF, 2020, 5, 5, 0, 2021, 4, 31);
        send_request(REQ_DIFF, 2020, 13, 5, 0, 2021, 4, 3);
        send_request(REQ_UNUSED, 2020, 5, 5, 7, 2021, 4, 3);
        send_request(REQ_ADD, 1999, 12, 31, 1, 1, 1, 1);
        start <= 0;
        while (pending != 0) @(posedge i_clk);
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = phase == 1 ? 66 : (phase == 3 ? 18 : 0);
            repeat (20) send_random();
        end
        start <= 0;
        while (pending != 0 && quiet_cycles < WATCHDOG) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
